@@ sv/scheduled_window_averager_macros.svh @@
// Assertion macros shared by the scheduled window averager RTL.
`ifndef SCHEDULED_WINDOW_AVERAGER_MACROS_SVH
`define SCHEDULED_WINDOW_AVERAGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SWA_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SWA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/swa_pkg.sv @@
// Package: shared constants, sequencer states and divider status for the window averager.
`default_nettype none

package swa_pkg;

  localparam int DEF_CHANNELS    = 6;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int STEP_BITS       = 48;
  localparam int SUM_BITS        = 48;
  localparam int REG_BITS        = 16;
  localparam int REG_IDX_BITS    = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_SAMPLE_SPACING      = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_SAMPLES_PER_AVERAGE = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_OUTPUT_PERIOD       = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_SCHED_GO   = 11'b000_0000_0010,
    S_SCHED_WAIT = 11'b000_0000_0100,
    S_SCHED_BASE = 11'b000_0000_1000,
    S_SCHED_WRAP = 11'b000_0001_0000,
    S_CHECK      = 11'b000_0010_0000,
    S_ACC        = 11'b000_0100_0000,
    S_COUNT      = 11'b000_1000_0000,
    S_DIV_GO     = 11'b001_0000_0000,
    S_DIV_WAIT   = 11'b010_0000_0000,
    S_OUT        = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

@@ sv/scheduled_window_averager.sv @@
// Top level: decimating boxcar averager with a step schedule and a shared serial divider.
`default_nettype none

// Each input beat is one simulation timestep: a step number and CHANNELS signed
// Q16.16 samples. A window is samples_per_average samples taken sample_spacing
// steps apart, ending on a multiple of output_period; a start beat clears the
// window and schedules its first sampling step, then counts as an ordinary step.
// When the window completes, one output beat carries the completing step number
// and the per-channel means (sum / samples_per_average, truncated toward zero,
// saturated to the sample range). A register that holds 0 acts as 1.
// Flow: every beat is checked against the schedule; a sampling beat then adds
// each channel into its sum and counts the sample; a start beat first runs the
// schedule division (step / period), and a window-closing beat divides each
// channel sum by n in turn. The single serial divider dominates the timing;
// one 48-bit adder serves the channel sums one per cycle.
// s_tready is high only while the sequencer is idle. A finished result sits in
// the output register, so the next input beat is taken while it waits; a
// second result waits in the sequencer until the first is taken.

module scheduled_window_averager #(
  parameter  int CHANNELS    = swa_pkg::DEF_CHANNELS,
  parameter  int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS,
  localparam int DATA_BITS   = ((swa_pkg::STEP_BITS + CHANNELS * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // step_number, sample_a, sample_b, ... (one per channel), zero pad
  input  wire logic [DATA_BITS-1:0]              s_tdata,
  // action (0 ordinary step, 1 start)
  input  wire logic                              s_tuser,
  // output stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // emit_step, mean_a, mean_b, ... (one per channel), zero pad
  output logic      [DATA_BITS-1:0]              m_tdata,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [swa_pkg::REG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [swa_pkg::REG_BITS-1:0]      cfg_data
);

`include "scheduled_window_averager_macros.svh"

  localparam int STEP_BITS  = swa_pkg::STEP_BITS;
  localparam int SUM_BITS   = swa_pkg::SUM_BITS;
  localparam int REG_BITS   = swa_pkg::REG_BITS;
  localparam int PROD_BITS  = 2 * REG_BITS;
  localparam int SCHED_BITS = STEP_BITS + 2;
  localparam int CHAN_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Saturation bounds for the means
  localparam logic [SUM_BITS-1:0]    MAG_HI  = (SUM_BITS'(1) << (SAMPLE_BITS - 1)) - SUM_BITS'(1);
  localparam logic [SUM_BITS-1:0]    MAG_LO  = SUM_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] MEAN_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MEAN_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Configuration registers
  logic [REG_BITS-1:0] sample_spacing;
  logic [REG_BITS-1:0] samples_per_average;
  logic [REG_BITS-1:0] output_period;
  logic [REG_BITS-1:0] sp_eff;
  logic [REG_BITS-1:0] n_eff;
  logic [REG_BITS-1:0] p_eff;
  logic [PROD_BITS-1:0] prod;
  logic [PROD_BITS-1:0] prod_next;

  // Sequencer and window state
  swa_pkg::state_t                 state;
  logic [CHAN_BITS-1:0]            chan;
  logic [REG_BITS-1:0]             samples_taken;
  logic [STEP_BITS-1:0]            next_sample_step;
  logic [SUM_BITS-1:0]             sums [CHANNELS];

  // Latched input beat
  logic [STEP_BITS-1:0]            in_step;
  logic signed [SAMPLE_BITS-1:0]   in_sample [CHANNELS];

  // Schedule working value and staged means
  logic signed [SCHED_BITS-1:0]    base;
  logic [SAMPLE_BITS-1:0]          means [CHANNELS];

  // Output register
  logic                            out_valid;
  logic                            out_load;
  logic [STEP_BITS-1:0]            out_step;
  logic [SAMPLE_BITS-1:0]          out_mean [CHANNELS];

  // Datapath nets
  logic                            in_accept;
  logic                            chan_last;
  logic [SUM_BITS-1:0]             cur_sum;
  logic [SUM_BITS-1:0]             acc_sum;
  logic                            sum_neg;
  logic [SUM_BITS-1:0]             sum_mag;
  logic [SUM_BITS-1:0]             neg_q;
  logic [SAMPLE_BITS-1:0]          mean_val;
  logic [REG_BITS-1:0]             cnt_inc;
  logic signed [SCHED_BITS-1:0]    ts_ext;
  logic signed [SCHED_BITS-1:0]    base_calc;
  logic [STEP_BITS-1:0]            sched_wrap;

  // Divider hookup
  logic                            div_start;
  logic [SUM_BITS-1:0]             div_dividend;
  logic [REG_BITS-1:0]             div_divisor;
  logic [SUM_BITS-1:0]             div_quo;
  logic [REG_BITS-1:0]             div_rem;
  swa_pkg::div_status_t            div_stat;

  // Zero registers behave as one
  assign sp_eff    = (sample_spacing == '0)      ? REG_BITS'(1) : sample_spacing;
  assign n_eff     = (samples_per_average == '0) ? REG_BITS'(1) : samples_per_average;
  assign p_eff     = (output_period == '0)       ? REG_BITS'(1) : output_period;
  // Window span (n - 1) * spacing, registered off the config registers
  assign prod_next = PROD_BITS'(n_eff - REG_BITS'(1)) * PROD_BITS'(sp_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_spacing      <= REG_BITS'(1);
      samples_per_average <= REG_BITS'(1);
      output_period       <= REG_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        swa_pkg::REG_SAMPLE_SPACING:      sample_spacing      <= cfg_data;
        swa_pkg::REG_SAMPLES_PER_AVERAGE: samples_per_average <= cfg_data;
        swa_pkg::REG_OUTPUT_PERIOD:       output_period       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  assign s_tready  = (state == swa_pkg::S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign chan_last = (chan == CHAN_BITS'(CHANNELS - 1));
  // Load a finished result once the output register is free or being taken
  assign out_load  = (state == swa_pkg::S_OUT) && (!out_valid || m_tready);

  // One shared adder walks the channels; the sum at chan also feeds the divider
  always_comb begin
    cur_sum = sums[chan];
    acc_sum = cur_sum + SUM_BITS'(in_sample[chan]);
    sum_neg = cur_sum[SUM_BITS-1];
    sum_mag = sum_neg ? (SUM_BITS'(0) - cur_sum) : cur_sum;
  end

  // Restore the sign of the quotient and clamp to the sample range
  always_comb begin
    neg_q = SUM_BITS'(0) - div_quo;
    if (!sum_neg) begin
      mean_val = (div_quo > MAG_HI) ? MEAN_HI : div_quo[SAMPLE_BITS-1:0];
    end else begin
      mean_val = (div_quo > MAG_LO) ? MEAN_LO : neg_q[SAMPLE_BITS-1:0];
    end
  end

  // First sampling step: round up to the period, back off the window span,
  // and push forward one period if that lands before the current step
  always_comb begin
    ts_ext = $signed({2'b00, in_step});
    if ((div_rem == '0) && (n_eff == REG_BITS'(1))) begin
      base_calc = ts_ext;
    end else begin
      base_calc = ts_ext - SCHED_BITS'(div_rem) + SCHED_BITS'(p_eff) - SCHED_BITS'(prod);
    end
    if (base < ts_ext) begin
      sched_wrap = STEP_BITS'(base + SCHED_BITS'(p_eff));
    end else begin
      sched_wrap = STEP_BITS'(base);
    end
  end

  assign cnt_inc = samples_taken + REG_BITS'(1);

  // Divider serves the schedule (step / period) and the means (|sum| / n)
  assign div_start    = (state == swa_pkg::S_SCHED_GO) || (state == swa_pkg::S_DIV_GO);
  assign div_dividend = (state == swa_pkg::S_SCHED_GO) ? SUM_BITS'(in_step) : sum_mag;
  assign div_divisor  = (state == swa_pkg::S_SCHED_GO) ? p_eff : n_eff;

  swa_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (REG_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= swa_pkg::S_IDLE;
      chan             <= '0;
      samples_taken    <= '0;
      next_sample_step <= '0;
      out_valid        <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums[i] <= '0;
      end
    end else begin
      // Load a finished result, or drop the output beat once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        swa_pkg::S_IDLE: begin
          if (in_accept) begin
            in_step <= s_tdata[STEP_BITS-1:0];
            for (int i = 0; i < CHANNELS; i++) begin
              in_sample[i] <= s_tdata[STEP_BITS + i * SAMPLE_BITS +: SAMPLE_BITS];
            end
            chan <= '0;
            if (s_tuser) begin
              // Start beat: clear the window, then schedule it
              samples_taken <= '0;
              for (int i = 0; i < CHANNELS; i++) begin
                sums[i] <= '0;
              end
              state <= swa_pkg::S_SCHED_GO;
            end else begin
              state <= swa_pkg::S_CHECK;
            end
          end
        end
        swa_pkg::S_SCHED_GO: begin
          state <= swa_pkg::S_SCHED_WAIT;
        end
        swa_pkg::S_SCHED_WAIT: begin
          if (div_stat.done) begin
            state <= swa_pkg::S_SCHED_BASE;
          end
        end
        swa_pkg::S_SCHED_BASE: begin
          base  <= base_calc;
          state <= swa_pkg::S_SCHED_WRAP;
        end
        swa_pkg::S_SCHED_WRAP: begin
          next_sample_step <= sched_wrap;
          state            <= swa_pkg::S_CHECK;
        end
        swa_pkg::S_CHECK: begin
          // Off-schedule steps leave no trace
          if (in_step == next_sample_step) begin
            state <= swa_pkg::S_ACC;
          end else begin
            state <= swa_pkg::S_IDLE;
          end
        end
        swa_pkg::S_ACC: begin
          sums[chan] <= acc_sum;
          if (chan_last) begin
            chan  <= '0;
            state <= swa_pkg::S_COUNT;
          end else begin
            chan <= chan + CHAN_BITS'(1);
          end
        end
        swa_pkg::S_COUNT: begin
          if (cnt_inc < n_eff) begin
            samples_taken    <= cnt_inc;
            next_sample_step <= next_sample_step + STEP_BITS'(sp_eff);
            state            <= swa_pkg::S_IDLE;
          end else begin
            // Window complete: schedule the next one and work out the means
            samples_taken    <= '0;
            next_sample_step <= in_step + STEP_BITS'(p_eff) - STEP_BITS'(prod);
            state            <= swa_pkg::S_DIV_GO;
          end
        end
        swa_pkg::S_DIV_GO: begin
          state <= swa_pkg::S_DIV_WAIT;
        end
        swa_pkg::S_DIV_WAIT: begin
          if (div_stat.done) begin
            means[chan] <= mean_val;
            sums[chan]  <= '0;
            if (chan_last) begin
              chan  <= '0;
              state <= swa_pkg::S_OUT;
            end else begin
              chan  <= chan + CHAN_BITS'(1);
              state <= swa_pkg::S_DIV_GO;
            end
          end
        end
        swa_pkg::S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            out_step  <= in_step;
            for (int i = 0; i < CHANNELS; i++) begin
              out_mean[i] <= means[i];
            end
            state <= swa_pkg::S_IDLE;
          end
        end
        default: begin
          state <= swa_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    m_tdata = '0;
    m_tdata[STEP_BITS-1:0] = out_step;
    for (int i = 0; i < CHANNELS; i++) begin
      m_tdata[STEP_BITS + i * SAMPLE_BITS +: SAMPLE_BITS] = out_mean[i];
    end
  end

  `SWA_ASSERT_SAME(a_div_start_free, div_start, !div_stat.busy, "divider restarted while busy")
  `SWA_ASSERT_SAME(a_div_done_waited, div_stat.done, (state == swa_pkg::S_SCHED_WAIT) || (state == swa_pkg::S_DIV_WAIT), "divider finished with no one waiting")
  `SWA_ASSERT_NEXT(a_start_clears, in_accept && s_tuser, samples_taken == '0, "start beat left a sample count")
  `SWA_ASSERT_SAME(a_emit_cleared, $rose(m_tvalid), samples_taken == '0, "result emitted with window still counting")
  `SWA_ASSERT_SAME(a_ready_div_idle, s_tready, !div_stat.busy, "input ready while divider busy")

endmodule

`default_nettype wire

@@ sv/swa_div.sv @@
// Serial restoring divider: unsigned quotient and remainder, one bit per clock.
`default_nettype none

module swa_div #(
  parameter int DIVIDEND_BITS = swa_pkg::SUM_BITS,
  parameter int DIVISOR_BITS  = swa_pkg::REG_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [DIVISOR_BITS-1:0]  divisor,
  output logic      [DIVIDEND_BITS-1:0] quotient,
  output logic      [DIVISOR_BITS-1:0]  remainder,
  output swa_pkg::div_status_t          status
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dsr;
  logic [CNT_BITS-1:0]      cnt;
  logic                     busy;
  logic                     done;

  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    shifted = {rem, quo[DIVIDEND_BITS-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= CNT_BITS'(DIVIDEND_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIVIDEND_BITS-2:0], fits};
        rem <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

@@ verif/scheduled_window_averager_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the window averager: directed beats from a table, then random windows.

module scheduled_window_averager_tb;

  localparam int CH     = swa_pkg::DEF_CHANNELS;
  localparam int SB     = swa_pkg::DEF_SAMPLE_BITS;
  localparam int STEP_W = swa_pkg::STEP_BITS;
  localparam int SUM_W  = swa_pkg::SUM_BITS;
  localparam int REG_W  = swa_pkg::REG_BITS;

  // Stop feeding once this many beats were taken.
  localparam int ITEMS          = 1250;
  // The last beats run with no idling on either side.
  localparam int CALM_TAIL      = 150;
  // Covers the worst single beat: a start plus a window close.
  localparam int SETTLE_CYCLES  = 450;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  localparam logic [STEP_W-1:0] STEP_TOP = '1;

  // Sample sets, channel f first, channel a last.
  localparam logic [CH-1:0][SB-1:0] ALL_MAX = {CH{32'h7FFF_FFFF}};
  localparam logic [CH-1:0][SB-1:0] ALL_MIN = {CH{32'h8000_0000}};
  localparam logic [CH-1:0][SB-1:0] MIXED   =
    {32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000};
  localparam logic [CH-1:0][SB-1:0] SPLIT   =
    {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
  // Three samples whose averages need truncation toward zero, negatives included.
  localparam logic [CH-1:0][SB-1:0] TRUNC_1 =
    {32'd2, -32'sd7, 32'd7, -32'sd5, 32'd1, -32'sd1};
  localparam logic [CH-1:0][SB-1:0] TRUNC_2 =
    {32'd0, 32'd0, 32'd0, -32'sd5, 32'd1, -32'sd1};
  localparam logic [CH-1:0][SB-1:0] TRUNC_3 =
    {32'd0, 32'd0, 32'd0, -32'sd5, 32'd0, 32'd0};

  // Beat layouts match tdata: step (or emit step) in the low bits, channel a next.
  typedef struct packed {
    logic [CH-1:0][SB-1:0] samples;
    logic [STEP_W-1:0]     step;
  } beat_t;

  typedef struct packed {
    logic [CH-1:0][SB-1:0] means;
    logic [STEP_W-1:0]     emit_step;
  } avg_t;

  typedef enum {BEAT_IGNORED, BEAT_SAMPLED, BEAT_CLOSED} beat_fate_t;
  typedef enum {ROW_CFG, ROW_BEAT} row_kind_t;
  typedef enum {STEP_GIVEN, STEP_SCHED} step_src_t;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;

  typedef struct {
    row_kind_t             kind;
    logic [REG_W-1:0]      spacing;
    logic [REG_W-1:0]      count;
    logic [REG_W-1:0]      period;
    logic                  action;
    step_src_t             src;
    logic [STEP_W-1:0]     step;
    logic [CH-1:0][SB-1:0] samples;
    row_check_t            check;
  } row_t;

  localparam int DATA_W = $bits(beat_t);

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [DATA_W-1:0]                s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b1;
  logic [DATA_W-1:0]                m_tdata;
  logic                             cfg_we = 1'b0;
  logic [swa_pkg::REG_IDX_BITS-1:0] cfg_index = swa_pkg::REG_SAMPLE_SPACING;
  logic [REG_W-1:0]                 cfg_data = '0;

  scheduled_window_averager u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: registers as written, then the window schedule and sums.
  logic [REG_W-1:0]  spacing_reg = 1;
  logic [REG_W-1:0]  count_reg   = 1;
  logic [REG_W-1:0]  period_reg  = 1;
  logic [STEP_W-1:0] sched_step  = '0;
  logic [REG_W-1:0]  taken       = '0;
  logic [SUM_W-1:0]  sums [CH];

  avg_t       averages_due [$];
  row_check_t beat_check = CHK_MODEL;
  avg_t       beat_typed;
  int         in_beats     = 0;
  int         fails        = 0;
  int         idle_cycles  = 0;
  int         stall_pct    = 5;
  int         gap_pct      = 20;
  bit         quiet        = 1'b0;

  // A register that holds 0 counts as 1.
  function automatic longint eff(input logic [REG_W-1:0] r);
    return (r == 0) ? 64'sd1 : longint'(r);
  endfunction

  // First sampling step after a start at step t: back off n-1 spacings from
  // the next multiple of the period, exact in 64 bits, then wrap to 48.
  function automatic logic [STEP_W-1:0] first_window_step(input logic [STEP_W-1:0] t);
    longint ts, sp, n, p, v;
    ts = longint'(t);
    sp = eff(spacing_reg);
    n  = eff(count_reg);
    p  = eff(period_reg);
    v  = (ts / p) * p + p;
    if (v - p == ts && n == 1)
      v = ts;
    else
      v -= (n - 1) * sp;
    if (v < ts)
      v += p;
    return v[STEP_W-1:0];
  endfunction

  // Advance the window schedule by one beat; fill avg when a window closes.
  function automatic beat_fate_t advance_schedule(input logic act, input beat_t b,
                                                  output avg_t avg);
    longint n, m, v;
    avg = '0;
    n = eff(count_reg);
    if (act) begin
      taken = '0;
      for (int i = 0; i < CH; i++) sums[i] = '0;
      sched_step = first_window_step(b.step);
    end
    if (b.step != sched_step)
      return BEAT_IGNORED;
    for (int i = 0; i < CH; i++)
      sums[i] = sums[i] + SUM_W'($signed(b.samples[i]));
    taken = taken + 1'b1;
    if (longint'(taken) < n) begin
      sched_step = sched_step + STEP_W'(eff(spacing_reg));
      return BEAT_SAMPLED;
    end
    avg.emit_step = b.step;
    for (int i = 0; i < CH; i++) begin
      m = longint'($signed(sums[i])) / n;
      if (m > SAMPLE_MAX) m = SAMPLE_MAX;
      if (m < SAMPLE_MIN) m = SAMPLE_MIN;
      avg.means[i] = m[SB-1:0];
      sums[i] = '0;
    end
    taken = '0;
    v = longint'(b.step) + eff(period_reg) - (n - 1) * eff(spacing_reg);
    sched_step = v[STEP_W-1:0];
    return BEAT_CLOSED;
  endfunction

  // Score outputs against the oldest expected average, then predict the input beat.
  always @(posedge clk) begin : scoreboard
    avg_t       got, want, pred;
    beat_fate_t fate;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (averages_due.size() == 0) begin
          $error("unexpected average beat, emit_step %0d", got.emit_step);
          fails++;
        end else begin
          want = averages_due.pop_front();
          if (got.emit_step !== want.emit_step) begin
            $error("emit_step: expected %0d, actual %0d", want.emit_step, got.emit_step);
            fails++;
          end
          for (int i = 0; i < CH; i++) begin
            if (got.means[i] !== want.means[i]) begin
              $error("mean_%c: expected %0d, actual %0d", 8'd97 + i,
                     $signed(want.means[i]), $signed(got.means[i]));
              fails++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fate = advance_schedule(s_tuser, beat_t'(s_tdata), pred);
        case (beat_check)
          CHK_MODEL: if (fate == BEAT_CLOSED) averages_due.push_back(pred);
          CHK_TYPED: averages_due.push_back(beat_typed);
          default: ;
        endcase
        in_beats++;
      end
    end
  end

  // Trip when no beat, output or register write moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output back-pressure: random stall bursts, none in the calm tail.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (!rst && !quiet && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one beat, maybe after a gap, and hold it until taken.
  task automatic send_beat(input logic act, input logic [STEP_W-1:0] step,
                           input logic [CH-1:0][SB-1:0] smp, input row_check_t chk);
    int target;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    beat_check = chk;
    beat_typed = {smp, step};
    target = in_beats + 1;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {smp, step};
    @(negedge clk);
    while (in_beats < target) @(negedge clk);
    if (in_beats >= ITEMS - CALM_TAIL) quiet = 1'b1;
  endtask

  // Drop valid, wait for every expected average, then let a silent beat finish.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (averages_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers on an idle block.
  task automatic reconfigure(input logic [REG_W-1:0] sp, input logic [REG_W-1:0] n,
                             input logic [REG_W-1:0] p);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= swa_pkg::REG_SAMPLE_SPACING;
    cfg_data  <= sp;
    @(negedge clk);
    cfg_index <= swa_pkg::REG_SAMPLES_PER_AVERAGE;
    cfg_data  <= n;
    @(negedge clk);
    cfg_index <= swa_pkg::REG_OUTPUT_PERIOD;
    cfg_data  <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    spacing_reg = sp;
    count_reg   = n;
    period_reg  = p;
  endtask

  function automatic row_t cfg_row(input logic [REG_W-1:0] sp, input logic [REG_W-1:0] n,
                                   input logic [REG_W-1:0] p);
    row_t r;
    r.kind    = ROW_CFG;
    r.spacing = sp;
    r.count   = n;
    r.period  = p;
    return r;
  endfunction

  function automatic row_t beat_row(input logic act, input step_src_t src,
                                    input logic [STEP_W-1:0] step,
                                    input logic [CH-1:0][SB-1:0] smp, input row_check_t chk);
    row_t r;
    r.kind    = ROW_BEAT;
    r.action  = act;
    r.src     = src;
    r.step    = step;
    r.samples = smp;
    r.check   = chk;
    return r;
  endfunction

  initial begin : stimulus
    row_t                  plan [$];
    logic [REG_W-1:0]      sp, n, p;
    logic [STEP_W-1:0]     step;
    logic [CH-1:0][SB-1:0] smp;
    logic                  act;
    int                    r;

    for (int i = 0; i < CH; i++) sums[i] = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats. Typed rows run with one sample per window, or saturate, so the
    // average equals the samples and the emit step is the beat's own step.
    plan = '{
      // reset settings: each scheduled step samples and closes at once, an off-schedule step is ignored
      beat_row(1'b1, STEP_GIVEN, 0,        ALL_MAX, CHK_TYPED),
      beat_row(1'b0, STEP_GIVEN, 1,        ALL_MIN, CHK_TYPED),
      beat_row(1'b0, STEP_GIVEN, STEP_TOP, MIXED,   CHK_NONE),
      beat_row(1'b0, STEP_GIVEN, 2,        MIXED,   CHK_TYPED),
      // zero registers act as one; schedule wraps past the top step
      cfg_row(0, 0, 0),
      beat_row(1'b1, STEP_GIVEN, STEP_TOP, MIXED,   CHK_TYPED),
      beat_row(1'b0, STEP_GIVEN, 0,        ALL_MIN, CHK_TYPED),
      // three samples two apart ending on a multiple of eight, negative truncation
      cfg_row(2, 3, 8),
      beat_row(1'b1, STEP_GIVEN, 5,  TRUNC_1, CHK_MODEL),
      beat_row(1'b0, STEP_GIVEN, 12, TRUNC_1, CHK_MODEL),
      beat_row(1'b0, STEP_GIVEN, 13, ALL_MAX, CHK_MODEL),
      beat_row(1'b0, STEP_GIVEN, 14, TRUNC_2, CHK_MODEL),
      beat_row(1'b0, STEP_GIVEN, 16, TRUNC_3, CHK_MODEL),
      // shrink the count mid-window: five samples close at once and saturate
      cfg_row(2, 5, 8),
      beat_row(1'b1, STEP_GIVEN, 16, SPLIT, CHK_MODEL),
      beat_row(1'b0, STEP_SCHED, 0,  SPLIT, CHK_MODEL),
      beat_row(1'b0, STEP_SCHED, 0,  SPLIT, CHK_MODEL),
      beat_row(1'b0, STEP_SCHED, 0,  SPLIT, CHK_MODEL),
      cfg_row(2, 1, 8),
      beat_row(1'b0, STEP_GIVEN, 24, SPLIT, CHK_TYPED),
      // start on a period boundary, and a start whose window lands past the top
      cfg_row(3, 1, 4),
      beat_row(1'b1, STEP_GIVEN, 8,            MIXED,   CHK_MODEL),
      beat_row(1'b1, STEP_GIVEN, STEP_TOP - 1, ALL_MAX, CHK_MODEL),
      beat_row(1'b0, STEP_SCHED, 0,            MIXED,   CHK_MODEL),
      // largest registers: the first step goes negative and wraps
      cfg_row(16'hFFFF, 16'hFFFF, 16'hFFFF),
      beat_row(1'b1, STEP_GIVEN, 0, ALL_MAX, CHK_MODEL),
      beat_row(1'b0, STEP_SCHED, 0, ALL_MIN, CHK_MODEL),
      beat_row(1'b0, STEP_SCHED, 0, MIXED,   CHK_MODEL)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        reconfigure(plan[i].spacing, plan[i].count, plan[i].period);
      else
        send_beat(plan[i].action, (plan[i].src == STEP_SCHED) ? sched_step : plan[i].step,
                  plan[i].samples, plan[i].check);
    end

    // Random phases: new settings, a start, then mostly beats on the schedule.
    while (in_beats < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      sp = REG_W'($urandom_range(1, 4));
      else if (r < 80) sp = 0;
      else if (r < 90) sp = REG_W'($urandom_range(5, 300));
      else             sp = 16'hFFFF;
      r = $urandom_range(0, 99);
      if (r < 70)      n = REG_W'($urandom_range(1, 5));
      else if (r < 80) n = 0;
      else if (r < 95) n = REG_W'($urandom_range(6, 12));
      else             n = 16'hFFFF;
      r = $urandom_range(0, 99);
      if (r < 60)      p = REG_W'(eff(n) * eff(sp) * $urandom_range(1, 3));
      else if (r < 70) p = 0;
      else if (r < 85) p = REG_W'($urandom_range(1, 50));
      else             p = 16'hFFFF;
      reconfigure(sp, n, p);

      // Some phases run without any idling at all.
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 35);

      act  = 1'b1;
      step = STEP_W'($urandom_range(0, 100));
      repeat ($urandom_range(20, 80)) begin
        for (int i = 0; i < CH; i++) begin
          r = $urandom_range(0, 99);
          if (r < 55)
            smp[i] = $urandom;
          else if (r < 75)
            smp[i] = SB'($urandom_range(0, 2000)) - SB'(1000);
          else
            case ($urandom_range(0, 3))
              0:       smp[i] = 32'h7FFF_FFFF;
              1:       smp[i] = 32'h8000_0000;
              2:       smp[i] = '0;
              default: smp[i] = '1;
            endcase
        end
        send_beat(act, step, smp, CHK_MODEL);

        // Pick the next beat: well-formed mostly, then near misses, noise and restarts.
        r    = $urandom_range(0, 99);
        act  = 1'b0;
        step = sched_step;
        if (r >= 78 && r < 82)
          step = sched_step + STEP_W'($urandom_range(1, 3));
        else if (r >= 82 && r < 86)
          step = sched_step - STEP_W'($urandom_range(1, 3));
        else if (r >= 86 && r < 92)
          step = STEP_W'({$urandom, $urandom});
        else if (r >= 92) begin
          act = 1'b1;
          case ($urandom_range(0, 4))
            0, 1:    step = STEP_W'($urandom_range(0, 100));
            2:       step = STEP_TOP - STEP_W'($urandom_range(0, 200));
            default: step = STEP_W'({$urandom, $urandom});
          endcase
        end
      end
    end

    quiesce();
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/swa_pkg.sv
sv/swa_div.sv
sv/scheduled_window_averager.sv
verif/scheduled_window_averager_tb.sv
